@@ rtl/dhi_pkg.sv @@
`timescale 1ns / 1ps
// dhi_pkg: widths, codes, hash helpers and control/status structs of the
// double-hash index table. Used by dhi_ctrl, dhi_datapath and the top level; no dependencies.
package dhi_pkg;

    // Sizing
    localparam int MAX_TABLE_BITS = 12;
    localparam int MIN_TABLE_BITS = 6;
    localparam int SLOT_W         = MAX_TABLE_BITS;
    localparam int SLOT_DEPTH     = 1 << MAX_TABLE_BITS;
    localparam int STACK_DEPTH    = 1 << (MAX_TABLE_BITS - 1);
    localparam int STACK_AW       = MAX_TABLE_BITS - 1;
    localparam int COUNT_W        = MAX_TABLE_BITS;
    localparam int INDEX_W        = MAX_TABLE_BITS - 1;
    localparam int BITS_W         = 4;
    localparam int KEY_W          = 64;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 3;
    localparam int OUT_DATA_W     = ((INDEX_W + COUNT_W + 7) / 8) * 8;

    // Hash folding: shifts by multiples of 5 (start) and 7 (step)
    localparam int START_SHIFT = 5;
    localparam int STEP_SHIFT  = 7;
    localparam int START_TERMS = KEY_W / START_SHIFT + 1;
    localparam int STEP_TERMS  = KEY_W / STEP_SHIFT + 1;

    localparam logic [KEY_W-1:0]   KEY_EMPTY   = KEY_W'(0);
    localparam logic [KEY_W-1:0]   KEY_REMOVED = KEY_W'(1);
    localparam logic [BITS_W-1:0]  BITS_RESET  = BITS_W'(MAX_TABLE_BITS);
    localparam logic [COUNT_W-1:0] GUARD_RESET = COUNT_W'(1) << (MAX_TABLE_BITS - 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_FIND   = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_e;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_RESERVED  = 3'd4,
        ST_CLEARED   = 3'd5
    } status_e;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // latch a new command word
        logic    clr_init;   // load new size, empty counters
        logic    clr_write;  // write one empty slot of the sweep
        logic    rd;         // read slot key and value
        logic    adv;        // step to next slot of the probe chain
        logic    ins;        // store key in current slot
        logic    rem;        // mark current slot removed, push index
        logic    res_set;    // record result code
        status_e res_status;
        logic    res_hit;    // result index comes from slot value
        logic    out_load;   // move result into the output register
    } dhi_cmd_t;

    // Datapath to controller
    typedef struct packed {
        cmd_e cmd;
        logic reserved;
        logic guard_zero;
        logic key_match;
        logic key_empty;
        logic key_removed;
        logic probe_last;
        logic sweep_last;
        logic out_free;
    } dhi_sts_t;

    // XOR of arithmetic right shifts of a 32-bit value by multiples of step
    function automatic logic [SLOT_W-1:0] fold_hash(input logic [31:0] v,
                                                    input int step,
                                                    input int terms);
        logic [31:0]        acc;
        logic signed [31:0] sv;
        acc = '0;
        sv  = signed'(v);
        for (int i = 0; i < terms; i++) begin
            acc = acc ^ 32'(sv >>> (step * i));
        end
        return acc[SLOT_W-1:0];
    endfunction

    function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
        logic [BITS_W-1:0] r;
        r = b;
        if (b < BITS_W'(MIN_TABLE_BITS)) begin
            r = BITS_W'(MIN_TABLE_BITS);
        end
        else if (b > BITS_W'(MAX_TABLE_BITS)) begin
            r = BITS_W'(MAX_TABLE_BITS);
        end
        return r;
    endfunction

endpackage

@@ rtl/dhi_ram.sv @@
`timescale 1ns / 1ps
// dhi_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/dhi_ctrl.sv @@
`timescale 1ns / 1ps
// dhi_ctrl: command sequencer of the double-hash index table.
// Depends on dhi_pkg; drives dhi_datapath through dhi_cmd_t.
module dhi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  dhi_pkg::dhi_sts_t sts,
    output dhi_pkg::dhi_cmd_t cmd
);

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DISP   = 9'b000000100,
        S_CLEAR  = 9'b000001000,
        S_READ   = 9'b000010000,
        S_CHECK  = 9'b000100000,
        S_INSERT = 9'b001000000,
        S_REMOVE = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_status = dhi_pkg::ST_FOUND;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_write = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (sts.cmd == dhi_pkg::CMD_CLEAR)
                begin
                    cmd.clr_init = 1'b1;
                    state_next   = S_CLEAR;
                end
                else if (sts.reserved)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = dhi_pkg::ST_RESERVED;
                    state_next     = S_DONE;
                end
                else if (sts.cmd == dhi_pkg::CMD_ADD && sts.guard_zero)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = dhi_pkg::ST_FULL;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (sts.sweep_last)
                begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = dhi_pkg::ST_CLEARED;
                    state_next     = S_DONE;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.cmd == dhi_pkg::CMD_ADD)
                begin
                    // first empty or removed slot takes the key
                    priority if (sts.key_empty || sts.key_removed)
                    begin
                        state_next = S_INSERT;
                    end
                    else if (sts.key_match)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = dhi_pkg::ST_FOUND;
                        cmd.res_hit    = 1'b1;
                        state_next     = S_DONE;
                    end
                    else if (sts.probe_last)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = dhi_pkg::ST_FULL;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.adv    = 1'b1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    priority if (sts.key_match)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = dhi_pkg::ST_FOUND;
                        if (sts.cmd == dhi_pkg::CMD_REMOVE)
                        begin
                            state_next = S_REMOVE;
                        end
                        else
                        begin
                            cmd.res_hit = 1'b1;
                            state_next  = S_DONE;
                        end
                    end
                    else if (sts.key_empty || sts.probe_last)
                    begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = dhi_pkg::ST_NOT_FOUND;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.adv    = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_INSERT:
            begin
                cmd.ins    = 1'b1;
                state_next = S_DONE;
            end
            S_REMOVE:
            begin
                cmd.rem    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // an accepted word is always dispatched next
    a_accept_disp: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_DISP))
        else $error("accepted word not dispatched");

    // no table update while waiting for a word
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(cmd.clr_write || cmd.ins || cmd.rem))
        else $error("table written while idle");

    // an insert always ends in the result state
    a_ins_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |=> (state_reg == S_DONE))
        else $error("insert not followed by result");

endmodule

@@ rtl/dhi_datapath.sv @@
`timescale 1ns / 1ps
// dhi_datapath: slot, value and free-index memories, hashing, counters and
// output register of the double-hash index table. Depends on dhi_pkg, dhi_ram.
module dhi_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [dhi_pkg::CMD_W-1:0]           s_tuser,
    input  logic [dhi_pkg::KEY_W-1:0]           s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dhi_pkg::STATUS_W-1:0]        m_tuser,
    output logic [dhi_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dhi_pkg::BITS_W-1:0]          cfg_data,
    input  dhi_pkg::dhi_cmd_t                   cmd,
    output dhi_pkg::dhi_sts_t                   sts
);

    // control state
    logic [dhi_pkg::BITS_W-1:0]  table_bits_reg, table_bits_next;
    logic [dhi_pkg::BITS_W-1:0]  active_bits_reg, active_bits_next;
    logic [dhi_pkg::COUNT_W-1:0] free_depth_reg, free_depth_next;
    logic [dhi_pkg::COUNT_W-1:0] issued_reg, issued_next;
    logic [dhi_pkg::COUNT_W-1:0] guard_reg, guard_next;
    logic [dhi_pkg::SLOT_W-1:0]  sweep_reg, sweep_next;
    logic                        m_valid_reg, m_valid_next;

    // per-command payload
    dhi_pkg::cmd_e               cmd_reg;
    logic [dhi_pkg::KEY_W-1:0]   key_reg;
    logic [dhi_pkg::SLOT_W-1:0]  slot_reg;
    logic [dhi_pkg::SLOT_W-1:0]  delta_reg;
    logic [dhi_pkg::SLOT_W-1:0]  probe_reg;
    dhi_pkg::status_e            res_status_reg;
    logic [dhi_pkg::INDEX_W-1:0] res_index_reg;
    dhi_pkg::status_e            out_status_reg;
    logic [dhi_pkg::INDEX_W-1:0] out_index_reg;
    logic [dhi_pkg::COUNT_W-1:0] out_live_reg;

    logic [dhi_pkg::SLOT_W-1:0]  slot_mask;
    logic [dhi_pkg::BITS_W-1:0]  new_bits;
    logic [dhi_pkg::KEY_W-1:0]   key_rd;
    logic [dhi_pkg::COUNT_W-1:0] val_rd;
    logic [dhi_pkg::COUNT_W-1:0] free_rd;
    logic [dhi_pkg::COUNT_W-1:0] new_value;
    logic [dhi_pkg::INDEX_W-1:0] hit_index;

    logic                        key_we;
    logic [dhi_pkg::SLOT_W-1:0]  key_waddr;
    logic [dhi_pkg::KEY_W-1:0]   key_wdata;

    assign slot_mask = ~({dhi_pkg::SLOT_W{1'b1}} << active_bits_reg);
    assign new_bits  = dhi_pkg::clamp_bits(table_bits_reg);
    assign new_value = (free_depth_reg != '0) ? free_rd
                                              : issued_reg + dhi_pkg::COUNT_W'(1);
    assign hit_index = dhi_pkg::INDEX_W'(val_rd - dhi_pkg::COUNT_W'(1));
    assign cfg_ready = 1'b1;

    // slot keys: sweep writes empty, insert writes key, remove writes tombstone
    assign key_we    = cmd.clr_write || cmd.ins || cmd.rem;
    assign key_waddr = cmd.clr_write ? sweep_reg : slot_reg;
    always_comb
    begin
        priority if (cmd.clr_write)
        begin
            key_wdata = dhi_pkg::KEY_EMPTY;
        end
        else if (cmd.ins)
        begin
            key_wdata = key_reg;
        end
        else
        begin
            key_wdata = dhi_pkg::KEY_REMOVED;
        end
    end

    dhi_ram #(
        .WIDTH (dhi_pkg::KEY_W),
        .DEPTH (dhi_pkg::SLOT_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (cmd.rd),
        .raddr (slot_reg),
        .rdata (key_rd)
    );

    dhi_ram #(
        .WIDTH (dhi_pkg::COUNT_W),
        .DEPTH (dhi_pkg::SLOT_DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (cmd.ins),
        .waddr (slot_reg),
        .wdata (new_value),
        .re    (cmd.rd),
        .raddr (slot_reg),
        .rdata (val_rd)
    );

    // free index stack; top is read once per command at load
    dhi_ram #(
        .WIDTH (dhi_pkg::COUNT_W),
        .DEPTH (dhi_pkg::STACK_DEPTH)
    ) u_free_ram (
        .clk   (clk),
        .we    (cmd.rem),
        .waddr (free_depth_reg[dhi_pkg::STACK_AW-1:0]),
        .wdata (val_rd),
        .re    (cmd.load),
        .raddr (dhi_pkg::STACK_AW'(free_depth_reg - dhi_pkg::COUNT_W'(1))),
        .rdata (free_rd)
    );

    // counters, size and output valid
    always_comb
    begin
        table_bits_next  = table_bits_reg;
        active_bits_next = active_bits_reg;
        free_depth_next  = free_depth_reg;
        issued_next      = issued_reg;
        guard_next       = guard_reg;
        sweep_next       = sweep_reg;
        m_valid_next     = m_valid_reg;
        if (cfg_valid)
        begin
            table_bits_next = cfg_data;
        end
        if (cmd.clr_init)
        begin
            active_bits_next = new_bits;
            free_depth_next  = '0;
            issued_next      = '0;
            guard_next       = dhi_pkg::COUNT_W'(1)
                               << dhi_pkg::BITS_W'(new_bits - dhi_pkg::BITS_W'(1));
            sweep_next       = '0;
        end
        if (cmd.clr_write)
        begin
            sweep_next = sweep_reg + dhi_pkg::SLOT_W'(1);
        end
        if (cmd.ins)
        begin
            if (free_depth_reg != '0)
            begin
                free_depth_next = free_depth_reg - dhi_pkg::COUNT_W'(1);
            end
            else
            begin
                issued_next = issued_reg + dhi_pkg::COUNT_W'(1);
            end
            if (key_rd == dhi_pkg::KEY_EMPTY)
            begin
                guard_next = guard_reg - dhi_pkg::COUNT_W'(1);
            end
        end
        if (cmd.rem)
        begin
            free_depth_next = free_depth_reg + dhi_pkg::COUNT_W'(1);
        end
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_bits_reg  <= dhi_pkg::BITS_RESET;
            active_bits_reg <= dhi_pkg::BITS_RESET;
            free_depth_reg  <= '0;
            issued_reg      <= '0;
            guard_reg       <= dhi_pkg::GUARD_RESET;
            sweep_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            table_bits_reg  <= table_bits_next;
            active_bits_reg <= active_bits_next;
            free_depth_reg  <= free_depth_next;
            issued_reg      <= issued_next;
            guard_reg       <= guard_next;
            sweep_reg       <= sweep_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // command word, probe position and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= dhi_pkg::cmd_e'(s_tuser);
            key_reg   <= s_tdata;
            slot_reg  <= dhi_pkg::fold_hash(s_tdata[31:0], dhi_pkg::START_SHIFT,
                                            dhi_pkg::START_TERMS) & slot_mask;
            delta_reg <= (dhi_pkg::fold_hash(s_tdata[31:0], dhi_pkg::STEP_SHIFT,
                                             dhi_pkg::STEP_TERMS) & slot_mask)
                         | dhi_pkg::SLOT_W'(1);
            probe_reg <= '0;
        end
        else if (cmd.adv)
        begin
            slot_reg  <= (slot_reg + delta_reg) & slot_mask;
            probe_reg <= probe_reg + dhi_pkg::SLOT_W'(1);
        end
        if (cmd.ins)
        begin
            res_status_reg <= dhi_pkg::ST_INSERTED;
            res_index_reg  <= dhi_pkg::INDEX_W'(new_value - dhi_pkg::COUNT_W'(1));
        end
        else if (cmd.res_set)
        begin
            res_status_reg <= cmd.res_status;
            res_index_reg  <= cmd.res_hit ? hit_index : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_live_reg   <= issued_reg - free_depth_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        sts.cmd         = cmd_reg;
        sts.reserved    = (key_reg == dhi_pkg::KEY_EMPTY) || (key_reg == dhi_pkg::KEY_REMOVED);
        sts.guard_zero  = (guard_reg == '0);
        sts.key_match   = (key_rd == key_reg);
        sts.key_empty   = (key_rd == dhi_pkg::KEY_EMPTY);
        sts.key_removed = (key_rd == dhi_pkg::KEY_REMOVED);
        sts.probe_last  = (probe_reg == slot_mask);
        sts.sweep_last  = (sweep_reg == slot_mask);
        sts.out_free    = !m_valid_reg || m_tready;
    end

    // output word: index low, live count above, zero pad
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = dhi_pkg::OUT_DATA_W'({out_live_reg, out_index_reg});

    // released indices never outnumber issued ones
    a_free_le_issued: assert property (@(posedge clk) disable iff (!rst_n)
        free_depth_reg <= issued_reg)
        else $error("free stack deeper than issued count");

    // a result never overwrites an untaken one
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("output register overwritten");

    // filling an empty slot needs guard left
    a_guard: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins && key_rd == dhi_pkg::KEY_EMPTY) |-> (guard_reg != '0))
        else $error("fill guard underflow");

endmodule

@@ rtl/double_hash_index_table.sv @@
`timescale 1ns / 1ps
// Key to dense index map with open addressing and double hashing.
// Instantiates dhi_ctrl and dhi_datapath; depends on dhi_pkg.
//
// One command word at a time: find, add or remove a 64-bit key, or clear the
// table. Each probe is one registered read of the slot memories (S_READ)
// followed by one compare (S_CHECK). A find, an add that hits or runs out
// of slots, and a remove that misses put their result word out from the
// result state after the last compare; an add that inserts and a remove
// that hits first go through a table-write state (S_INSERT or S_REMOVE).
// Rejected (reserved) keys and a full guard answer straight from dispatch,
// without probing. A clear sweeps 2^table_bits slot entries (table_bits
// clamped to 6..12) at one per cycle and then answers. The next word is
// taken the cycle after its predecessor's result enters the output register.
// The output register lets a new word in while a result waits; that word
// then holds in its final state, with the input stalled, until the waiting
// result is taken. After reset the block runs a clearing pass over all 4096
// slots and accepts no word until it ends; table_bits writes are taken at
// any time and apply at the next clear.
module double_hash_index_table (
    input  logic                               clk,
    input  logic                               rst_n,
    // command word
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dhi_pkg::CMD_W-1:0]          s_tuser,   // [1:0] command
    input  logic [dhi_pkg::KEY_W-1:0]          s_tdata,   // [63:0] key
    // result word
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dhi_pkg::STATUS_W-1:0]       m_tuser,   // [2:0] status
    output logic [dhi_pkg::OUT_DATA_W-1:0]     m_tdata,   // [10:0] index, [22:11] live_count
    // table_bits register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dhi_pkg::BITS_W-1:0]         cfg_data
);

    dhi_pkg::dhi_cmd_t cmd;
    dhi_pkg::dhi_sts_t sts;

    dhi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dhi_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

@@ tb/sv/dhi_tb_pkg.sv @@
`timescale 1ns / 1ps
// dhi_tb_pkg: scoreboard for the double-hash index table bench, holding its own
// copy of the slot table, free stack and counters. Depends on dhi_pkg.
package dhi_tb_pkg;

    import dhi_pkg::*;

    // One expected result word, with the command that caused it
    typedef struct {
        cmd_e               cmd;
        logic [KEY_W-1:0]   key;
        status_e            status;
        logic [INDEX_W-1:0] index;
        logic [COUNT_W-1:0] live;
    } answer_t;

    class dhi_scoreboard;
        answer_t answers_q[$];
        int      errors;
        int      words_seen;
        int      status_hits[8];

        // model of the table
        logic [KEY_W-1:0]   slot_key [SLOT_DEPTH];
        logic [COUNT_W-1:0] slot_val [SLOT_DEPTH];
        logic [COUNT_W-1:0] freed    [STACK_DEPTH];
        int unsigned        free_top;
        int unsigned        issued;
        int unsigned        guard;
        int unsigned        size_reg;
        int unsigned        size_bits;

        function new();
            errors     = 0;
            words_seen = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
            foreach (slot_val[i]) slot_val[i] = '0;
            foreach (freed[i]) freed[i] = '0;
            size_reg = MAX_TABLE_BITS;
            wipe();
        endfunction

        // clear: empty every slot, reset counters, load the clamped size
        function void wipe();
            foreach (slot_key[i]) slot_key[i] = KEY_EMPTY;
            free_top  = 0;
            issued    = 0;
            size_bits = (size_reg < MIN_TABLE_BITS) ? MIN_TABLE_BITS :
                        (size_reg > MAX_TABLE_BITS) ? MAX_TABLE_BITS : size_reg;
            guard     = 1 << (size_bits - 1);
        endfunction

        function void note_bits(logic [BITS_W-1:0] v);
            size_reg = v;
        endfunction

        // XOR of the sign-extended low word shifted right by 0, s, 2s, ...
        function int unsigned fold_low_word(logic [31:0] v, int unsigned s,
                                            int unsigned terms);
            logic signed [63:0] wide;
            logic [31:0]        acc;
            wide = {{32{v[31]}}, v};
            acc  = '0;
            for (int unsigned i = 0; i < terms; i++)
                acc ^= 32'(wide >>> (s * i));
            return acc;
        endfunction

        // apply one accepted command word to the table, queue its answer
        function void note_command(cmd_e c, logic [KEY_W-1:0] k);
            answer_t          a;
            int unsigned      mask;
            int unsigned      slot;
            int unsigned      delta;
            int unsigned      v;
            int unsigned      idx_val;
            logic [KEY_W-1:0] held;

            mask     = (1 << size_bits) - 1;
            slot     = fold_low_word(k[31:0], START_SHIFT, START_TERMS) & mask;
            delta    = (fold_low_word(k[31:0], STEP_SHIFT, STEP_TERMS) & mask) | 1;
            a.cmd    = c;
            a.key    = k;
            a.status = ST_NOT_FOUND;
            idx_val  = 0;

            if (c == CMD_CLEAR)
            begin
                wipe();
                a.status = ST_CLEARED;
            end
            else if (k == KEY_EMPTY || k == KEY_REMOVED)
            begin
                a.status = ST_RESERVED;
            end
            else if (c == CMD_ADD)
            begin
                // spent guard answers full before probing
                a.status = ST_FULL;
                if (guard != 0)
                begin
                    for (int unsigned n = 0; n <= mask; n++)
                    begin
                        held = slot_key[slot];
                        // first empty or removed slot on the chain takes the key
                        if (held == KEY_EMPTY || held == KEY_REMOVED)
                        begin
                            if (held == KEY_EMPTY)
                                guard--;
                            slot_key[slot] = k;
                            if (free_top != 0)
                            begin
                                free_top--;
                                v = freed[free_top & (STACK_DEPTH - 1)];
                            end
                            else
                            begin
                                issued++;
                                v = issued;
                            end
                            slot_val[slot] = COUNT_W'(v);
                            idx_val  = v - 1;
                            a.status = ST_INSERTED;
                            break;
                        end
                        if (held == k)
                        begin
                            idx_val  = slot_val[slot] - 1;
                            a.status = ST_FOUND;
                            break;
                        end
                        slot = (slot + delta) & mask;
                    end
                end
            end
            else
            begin
                // find or remove: walk until the key or an empty slot
                for (int unsigned n = 0; n <= mask; n++)
                begin
                    held = slot_key[slot];
                    if (held == k)
                    begin
                        a.status = ST_FOUND;
                        if (c == CMD_FIND)
                        begin
                            idx_val = slot_val[slot] - 1;
                        end
                        else
                        begin
                            slot_key[slot] = KEY_REMOVED;
                            freed[free_top & (STACK_DEPTH - 1)] = slot_val[slot];
                            free_top++;
                        end
                        break;
                    end
                    if (held == KEY_EMPTY)
                        break;
                    slot = (slot + delta) & mask;
                end
            end

            a.index = INDEX_W'(idx_val);
            a.live  = COUNT_W'(issued - free_top);
            answers_q.push_back(a);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("MISMATCH %s", what);
        endtask

        // compare one result word with the oldest pending answer
        task check_result(logic [STATUS_W-1:0] st, logic [INDEX_W-1:0] idx,
                          logic [COUNT_W-1:0] live);
            answer_t a;
            words_seen++;
            if (answers_q.size() == 0)
            begin
                report($sformatf("unexpected result word: status %0d index %0d live %0d",
                                 st, idx, live));
                return;
            end
            a = answers_q.pop_front();
            status_hits[a.status]++;
            if (st !== a.status)
                report($sformatf("cmd %0d key %h: status %0d, want %0d",
                                 a.cmd, a.key, st, a.status));
            if (idx !== a.index)
                report($sformatf("cmd %0d key %h: index %0d, want %0d",
                                 a.cmd, a.key, idx, a.index));
            if (live !== a.live)
                report($sformatf("cmd %0d key %h: live_count %0d, want %0d",
                                 a.cmd, a.key, live, a.live));
        endtask
    endclass

endpackage

@@ tb/sv/tb_double_hash_index_table.sv @@
`timescale 1ns / 1ps
// tb_double_hash_index_table: directed and random command words into the
// double-hash index table, results checked by dhi_scoreboard. Needs dhi_pkg, dhi_tb_pkg.
module tb_double_hash_index_table;

    import dhi_pkg::*;
    import dhi_tb_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 100;
    localparam int PHASE_WORDS = 172;
    localparam int PLAN_LEN    = 8;
    localparam int DIR_LEN     = 24;

    // directed keys: extremes, and three keys sharing one low word
    localparam logic [KEY_W-1:0] K_MIN   = 64'h8000_0000_0000_0000;
    localparam logic [KEY_W-1:0] K_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] K_NEG1  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] K_TWIN  = 64'h0000_0001_0000_0000;
    localparam logic [KEY_W-1:0] K_STRAY = 64'h1234_5678_0000_0000;
    localparam logic [KEY_W-1:0] K_TWO   = 64'h0000_0000_0000_0002;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [CMD_W-1:0]      s_tuser;   // [1:0] command
    logic [KEY_W-1:0]      s_tdata;   // [63:0] key
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [STATUS_W-1:0]   m_tuser;   // [2:0] status
    logic [OUT_DATA_W-1:0] m_tdata;   // [10:0] index, [22:11] live_count
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [BITS_W-1:0]     cfg_data;

    dhi_scoreboard    sb;
    logic [KEY_W-1:0] key_pool [96];
    int               pool_size;
    int               tx_idle_pct;
    int               rx_stall_pct;
    int               hold_ticket;
    int               hold_served;
    int               hold_left;
    int               cycles;
    int               sizes_run;
    int               words_sent;

    double_hash_index_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // offer one command word after a random gap, wait for the handshake
    task automatic send_word(cmd_e c, logic [KEY_W-1:0] k);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= k;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_command(c, k);
        words_sent++;
    endtask

    // stop offering until every pending answer has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.answers_q.size() != 0);
    endtask

    // result side: check accepted words, random stalls, long hold on request
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
            sb.check_result(m_tuser, m_tdata[INDEX_W-1:0],
                            m_tdata[INDEX_W+COUNT_W-1:INDEX_W]);
        if (hold_ticket != hold_served)
        begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d answers pending", cycles,
                     sb.answers_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        cmd_e              dir_cmd  [DIR_LEN];
        logic [KEY_W-1:0]  dir_key  [DIR_LEN];
        logic [BITS_W-1:0] bit_plan [PLAN_LEN];
        cmd_e              c;
        logic [KEY_W-1:0]  k;
        int                roll;
        int                eff;

        sb        = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= CMD_FIND;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;

        dir_cmd = '{CMD_FIND, CMD_ADD, CMD_REMOVE, CMD_FIND, CMD_ADD, CMD_ADD,
                    CMD_ADD, CMD_FIND, CMD_ADD, CMD_ADD, CMD_REMOVE, CMD_FIND,
                    CMD_ADD, CMD_FIND, CMD_REMOVE, CMD_FIND, CMD_REMOVE, CMD_REMOVE,
                    CMD_ADD, CMD_REMOVE, CMD_CLEAR, CMD_FIND, CMD_ADD, CMD_FIND};
        dir_key = '{KEY_EMPTY, KEY_REMOVED, KEY_EMPTY, K_MIN, K_MIN, K_TWIN,
                    K_MIN, K_TWIN, K_MAX, K_NEG1, K_MIN, K_MIN,
                    K_TWIN, K_TWIN, K_TWIN, K_TWIN, K_STRAY, K_NEG1,
                    K_TWO, KEY_REMOVED, K_NEG1, K_MAX, K_MAX, KEY_REMOVED};
        // register values, clamped ones included
        bit_plan = '{4'd6, 4'd9, 4'd12, 4'd0, 4'd15, 4'd7, 4'd6, 4'd10};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reserved keys, hits, misses, removed slot reuse on a
        // shared chain, then a clear followed by a find, an add and a find; table at its reset size
        tx_idle_pct = 0;
        sizes_run   = 1;
        for (int d = 0; d < DIR_LEN; d++)
            send_word(dir_cmd[d], dir_key[d]);

        // random phases, one table size and one idling pattern each
        for (int p = 0; p < PLAN_LEN; p++)
        begin
            wait_drained();
            case (p % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                end
                1:
                begin
                    tx_idle_pct = 47;
                    rx_stall_pct <= 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 47;
                end
                default:
                begin
                    tx_idle_pct = 6;
                    rx_stall_pct <= 6;
                end
            endcase

            // new table_bits, applied by the clear that follows
            cfg_valid <= 1'b1;
            cfg_data  <= bit_plan[p];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            cfg_valid <= 1'b0;
            sb.note_bits(bit_plan[p]);
            sizes_run++;

            // key pool a bit larger than the guard on small tables
            eff = (bit_plan[p] < MIN_TABLE_BITS) ? MIN_TABLE_BITS :
                  (bit_plan[p] > MAX_TABLE_BITS) ? MAX_TABLE_BITS : int'(bit_plan[p]);
            pool_size = (eff <= 7) ? (3 << (eff - 2)) : 80;
            for (int j = 0; j < pool_size; j++)
            begin
                // some keys share a low word, hence a whole probe chain
                if (j >= 4 && $urandom_range(3) == 0)
                    key_pool[j] = {$urandom, key_pool[$urandom_range(j - 1)][31:0]};
                else
                    key_pool[j] = {$urandom, $urandom};
                if (key_pool[j] <= KEY_REMOVED)
                    key_pool[j] = key_pool[j] | K_TWIN;
            end

            send_word(CMD_CLEAR, {$urandom, $urandom});
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                roll = $urandom_range(99);
                k    = key_pool[$urandom_range(pool_size - 1)];
                c    = CMD_FIND;
                if (roll < 40)
                    c = CMD_ADD;
                else if (roll < 64)
                    c = CMD_FIND;
                else if (roll < 88)
                    c = CMD_REMOVE;
                else if (roll < 89)
                    c = CMD_CLEAR;
                else
                begin
                    // noise: fresh random keys and reserved keys
                    c = cmd_e'(CMD_W'($urandom_range(2)));
                    if (roll < 96)
                        k = {$urandom, $urandom};
                    else
                        k = ($urandom_range(1) == 0) ? KEY_EMPTY : KEY_REMOVED;
                end
                // long result-side hold while words keep coming
                if (p % 4 == 0 && i == PHASE_WORDS / 3)
                    hold_ticket <= hold_ticket + 1;
                if (i == 2 * PHASE_WORDS / 3)
                    wait_drained();
                send_word(c, k);
            end
        end

        wait_drained();
        rx_stall_pct <= 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.answers_q.size() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.answers_q.size()));

        $display("Ran %0d commands over %0d table sizes: %0d inserted, %0d found,",
                 words_sent, sizes_run, sb.status_hits[ST_INSERTED], sb.status_hits[ST_FOUND]);
        $display("%0d not found, %0d full, %0d reserved, %0d cleared; %0d mismatches",
                 sb.status_hits[ST_NOT_FOUND], sb.status_hits[ST_FULL],
                 sb.status_hits[ST_RESERVED], sb.status_hits[ST_CLEARED], sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
